>>> src/rlpf_pkg.sv
// Shared types, constants and helpers for the radio link pairing framer.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rlpf_pkg;

  localparam int RX_FRAME_BYTES = 10;
  localparam int TX_FRAME_BYTES = 13;
  localparam int TX_CNT_W       = $clog2(TX_FRAME_BYTES);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  localparam logic [2:0] FUNC_RX     = 3'd0;
  localparam logic [2:0] FUNC_SEND   = 3'd1;
  localparam logic [2:0] FUNC_UNPAIR = 3'd2;
  localparam logic [2:0] FUNC_PAIR   = 3'd3;
  localparam logic [2:0] FUNC_REFUEL = 3'd4;
  localparam logic [2:0] FUNC_SHOOT  = 3'd5;
  localparam logic [2:0] FUNC_ADDR   = 3'd6;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_PAIRED = 2'd1;
  localparam logic [1:0] KIND_FUEL   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] LINK_DRIVE  = 2'd0;
  localparam logic [1:0] LINK_CHARGE = 2'd1;
  localparam logic [1:0] LINK_PAIR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDPOINT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ADDR = 2'd2;

  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;
  localparam logic [7:0] RX_LEN_BYTE = 8'h06;
  localparam logic [7:0] TX_LEN_BYTE = 8'h09;
  localparam logic [7:0] TX_API_BYTE = 8'h01;
  localparam logic [7:0] BOAT_HI     = 8'h81;
  localparam logic [7:0] NET_BYTE    = 8'h20;
  localparam logic [7:0] PAIR_CMD    = 8'h21;
  localparam logic [7:0] SUM_BASE    = 8'hFF;

  localparam logic [7:0] BAND_1 = 8'd51;
  localparam logic [7:0] BAND_2 = 8'd102;
  localparam logic [7:0] BAND_3 = 8'd153;
  localparam logic [7:0] BAND_4 = 8'd204;

  localparam logic [15:0] PENDING_STEP  = 16'd5;
  localparam logic [15:0] PENDING_LIMIT = 16'd65530;
  localparam logic [15:0] PENDING_MAX   = 16'hFFFF;

  localparam logic [6:0] DEAD_BAND_RST = 7'd5;
  localparam logic [7:0] MIDPOINT_RST  = 8'd127;
  localparam logic [7:0] CTRL_ADDR_RST = 8'd129;
  localparam logic [7:0] TARGET_RST    = 8'h81;

  typedef struct packed {
    logic       is_frame;
    logic [1:0] kind;
    logic [7:0] data;
    logic       restart;
    logic       paired;
    logic       lamp;
    logic [7:0] target;
    logic [1:0] status;
    logic [7:0] pay0;
    logic [7:0] pay1;
    logic [7:0] pay2;
    logic [7:0] csum;
  } job_t;

  function automatic logic [7:0] addr_lookup(input logic [2:0] idx);
    logic [7:0] a;
    case (idx)
      3'd0:    a = 8'h00;
      3'd1:    a = 8'h81;
      3'd2:    a = 8'h82;
      3'd3:    a = 8'h83;
      3'd4:    a = 8'h84;
      3'd5:    a = 8'h85;
      default: a = 8'h00;
    endcase
    return a;
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] v);
    return (v > PENDING_LIMIT) ? PENDING_MAX : v + PENDING_STEP;
  endfunction

endpackage

`default_nettype wire

>>> src/rlpf_front.sv
// Front end: accepts event words, keeps link state and configuration, builds jobs.
// Depends on rlpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpf_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [rlpf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [rlpf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire                          accept_i,
  input  wire [2:0]                    func_i,
  input  wire [7:0]                    rx_data_i,
  input  wire [9:0]                    joy1_sample_i,
  input  wire [9:0]                    joy2_sample_i,
  input  wire [9:0]                    pot_sample_i,
  input  wire [2:0]                    addr_index_i,
  output rlpf_pkg::job_t               job_o
);
  import rlpf_pkg::*;

  logic [7:0]  win_q [RX_FRAME_BYTES];
  logic [7:0]  win_d [RX_FRAME_BYTES];
  logic        active_q, active_d;
  logic        paired_q, paired_d;
  logic [1:0]  status_q, status_d;
  logic [7:0]  target_q, target_d;
  logic [15:0] charge_q, charge_d;
  logic [15:0] shoot_q, shoot_d;
  logic        lamp_q, lamp_d;
  logic [6:0]  dead_band_q;
  logic [7:0]  mid_q;
  logic [7:0]  ctrl_addr_q;

  function automatic logic [7:0] joy_byte(input logic [9:0] sample, input logic [7:0] mid,
                                          input logic [6:0] db);
    logic signed [9:0] v;
    logic signed [9:0] hi;
    logic signed [9:0] lo;
    v  = {2'b00, sample[9:2]};
    hi = $signed({2'b00, mid} + {3'b000, db});
    lo = $signed({2'b00, mid} - {3'b000, db});
    return ((v < hi) && (v > lo)) ? mid : sample[9:2];
  endfunction

  logic [7:0] shifted [RX_FRAME_BYTES];
  logic [7:0] rx_sum;
  logic       rx_ok;
  logic       digi;
  logic [1:0] st;
  logic [7:0] p0, p1, p2;
  logic [7:0] pot;

  always_comb begin
    for (int i = 0; i < RX_FRAME_BYTES - 1; i++) begin
      shifted[i] = win_q[i+1];
    end
    shifted[RX_FRAME_BYTES-1] = rx_data_i;
    rx_sum = 8'h00;
    for (int i = 3; i < RX_FRAME_BYTES - 1; i++) begin
      rx_sum = rx_sum + shifted[i];
    end
    rx_sum = SUM_BASE - rx_sum;
    rx_ok = (shifted[0] == FLAG_BYTE) && (shifted[RX_FRAME_BYTES-1] == rx_sum) &&
            (shifted[1] == ZERO_BYTE) && (shifted[2] == RX_LEN_BYTE) &&
            (shifted[3] == BOAT_HI) && (shifted[4] == NET_BYTE);

    digi = (shoot_q != 16'd0);
    st   = status_q;
    if (st == LINK_CHARGE && charge_q == 16'd0) begin
      st = LINK_DRIVE;
    end
    pot = pot_sample_i[9:2];

    win_d    = win_q;
    active_d = active_q;
    paired_d = paired_q;
    status_d = status_q;
    target_d = target_q;
    charge_d = charge_q;
    shoot_d  = shoot_q;
    lamp_d   = lamp_q;
    p0 = ZERO_BYTE;
    p1 = ZERO_BYTE;
    p2 = ZERO_BYTE;

    job_o          = '0;
    job_o.kind     = KIND_STATUS;

    case (func_i)
      FUNC_RX: begin
        if (rx_data_i == FLAG_BYTE) begin
          for (int i = 0; i < RX_FRAME_BYTES; i++) begin
            win_d[i] = ZERO_BYTE;
          end
          win_d[RX_FRAME_BYTES-1] = FLAG_BYTE;
          active_d = 1'b1;
        end else if (active_q) begin
          win_d = shifted;
          if (rx_ok) begin
            active_d = 1'b0;
            if (shifted[5] == target_q) begin
              job_o.restart = 1'b1;
              if (!paired_q) begin
                paired_d   = 1'b1;
                status_d   = LINK_DRIVE;
                job_o.kind = KIND_PAIRED;
              end else begin
                job_o.kind = KIND_FUEL;
                job_o.data = shifted[8];
              end
            end
          end
        end
      end
      FUNC_SEND: begin
        shoot_d = shoot_q - {15'd0, digi};
        case (st)
          LINK_PAIR: begin
            p0 = PAIR_CMD;
            p1 = ctrl_addr_q;
          end
          LINK_CHARGE: begin
            charge_d = charge_q - 16'd1;
            lamp_d   = 1'b0;
          end
          default: begin
            p0 = joy_byte(joy1_sample_i, mid_q, dead_band_q);
            p1 = joy_byte(joy2_sample_i, mid_q, dead_band_q);
            p2 = {7'd0, digi};
          end
        endcase
        job_o.is_frame = 1'b1;
        job_o.kind     = KIND_FRAME;
      end
      FUNC_UNPAIR: begin
        paired_d = 1'b0;
        status_d = LINK_PAIR;
      end
      FUNC_PAIR: begin
        if (pot < BAND_1) begin
          target_d = addr_lookup(3'd1);
        end else if (pot < BAND_2) begin
          target_d = addr_lookup(3'd2);
        end else if (pot < BAND_3) begin
          target_d = addr_lookup(3'd3);
        end else if (pot < BAND_4) begin
          target_d = addr_lookup(3'd4);
        end else begin
          target_d = addr_lookup(3'd5);
        end
        status_d = LINK_PAIR;
      end
      FUNC_REFUEL: begin
        if (paired_q) begin
          lamp_d   = 1'b1;
          status_d = LINK_CHARGE;
          charge_d = sat_add(charge_q);
        end
      end
      FUNC_SHOOT: begin
        if (paired_q) begin
          shoot_d = sat_add(shoot_q);
        end
      end
      FUNC_ADDR: begin
        if (addr_index_i <= 3'd5) begin
          target_d = addr_lookup(addr_index_i);
        end
      end
      default: begin
      end
    endcase

    job_o.paired = paired_d;
    job_o.lamp   = lamp_d;
    job_o.target = target_q;
    job_o.status = st;
    job_o.pay0   = p0;
    job_o.pay1   = p1;
    job_o.pay2   = p2;
    job_o.csum   = SUM_BASE - (TX_API_BYTE + ZERO_BYTE + NET_BYTE + target_q + TX_API_BYTE +
                               {6'd0, st} + p0 + p1 + p2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RX_FRAME_BYTES; i++) begin
        win_q[i] <= ZERO_BYTE;
      end
      active_q    <= 1'b0;
      paired_q    <= 1'b0;
      status_q    <= LINK_PAIR;
      target_q    <= TARGET_RST;
      charge_q    <= 16'd0;
      shoot_q     <= 16'd0;
      lamp_q      <= 1'b0;
      dead_band_q <= DEAD_BAND_RST;
      mid_q       <= MIDPOINT_RST;
      ctrl_addr_q <= CTRL_ADDR_RST;
    end else begin
      if (accept_i) begin
        win_q    <= win_d;
        active_q <= active_d;
        paired_q <= paired_d;
        status_q <= status_d;
        target_q <= target_d;
        charge_q <= charge_d;
        shoot_q  <= shoot_d;
        lamp_q   <= lamp_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DEAD_BAND: dead_band_q <= cfg_data_i[6:0];
          CFG_MIDPOINT:  mid_q       <= cfg_data_i;
          CFG_CTRL_ADDR: ctrl_addr_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> src/rlpf_queue.sv
// Short job queue between the front end and the byte serialiser.
// Depends on rlpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpf_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire rlpf_pkg::job_t  push_job_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output logic                 valid_o,
  output rlpf_pkg::job_t       head_o
);
  import rlpf_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? next_ptr(wr_q) : wr_q;
    rd_d  = pop_i ? next_ptr(rd_q) : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> src/rlpf_back.sv
// Back end: takes jobs from the queue and drives result words, one per cycle unless the output stalls.
// Depends on rlpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpf_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  job_valid_i,
  input  wire rlpf_pkg::job_t  job_i,
  output logic                 job_pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [1:0]           out_kind_o,
  output logic [7:0]           data_byte_o,
  output logic                 last_of_run_o,
  output logic                 paired_flag_o,
  output logic                 charge_led_o,
  output logic                 restart_unpair_o
);
  import rlpf_pkg::*;

  job_t                cur_q, cur_d;
  logic                busy_q, busy_d;
  logic [TX_CNT_W-1:0] cnt_q, cnt_d;
  logic                valid_q, valid_d;
  logic [1:0]          kind_q, kind_d;
  logic [7:0]          data_q, data_d;
  logic                last_q, last_d;
  logic                paired_q, paired_d;
  logic                lamp_q, lamp_d;
  logic                restart_q, restart_d;
  logic                load;

  function automatic logic [7:0] frame_byte(input job_t j, input logic [TX_CNT_W-1:0] n);
    logic [7:0] b;
    case (n)
      4'd0:    b = FLAG_BYTE;
      4'd1:    b = ZERO_BYTE;
      4'd2:    b = TX_LEN_BYTE;
      4'd3:    b = TX_API_BYTE;
      4'd4:    b = ZERO_BYTE;
      4'd5:    b = NET_BYTE;
      4'd6:    b = j.target;
      4'd7:    b = TX_API_BYTE;
      4'd8:    b = {6'd0, j.status};
      4'd9:    b = j.pay0;
      4'd10:   b = j.pay1;
      4'd11:   b = j.pay2;
      4'd12:   b = j.csum;
      default: b = ZERO_BYTE;
    endcase
    return b;
  endfunction

  always_comb begin
    load      = !valid_q || !out_stall_i;
    job_pop_o = 1'b0;
    cur_d     = cur_q;
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    valid_d   = valid_q;
    kind_d    = kind_q;
    data_d    = data_q;
    last_d    = last_q;
    paired_d  = paired_q;
    lamp_d    = lamp_q;
    restart_d = restart_q;
    if (load) begin
      if (busy_q) begin
        valid_d = 1'b1;
        kind_d  = KIND_FRAME;
        data_d  = frame_byte(cur_q, cnt_q);
        last_d  = (cnt_q == TX_CNT_W'(TX_FRAME_BYTES - 1));
        cnt_d   = cnt_q + TX_CNT_W'(1);
        if (cnt_q == TX_CNT_W'(TX_FRAME_BYTES - 1)) begin
          busy_d = 1'b0;
        end
      end else if (job_valid_i) begin
        job_pop_o = 1'b1;
        valid_d   = 1'b1;
        paired_d  = job_i.paired;
        lamp_d    = job_i.lamp;
        restart_d = job_i.restart;
        kind_d    = job_i.kind;
        if (job_i.is_frame) begin
          cur_d  = job_i;
          busy_d = 1'b1;
          cnt_d  = TX_CNT_W'(1);
          data_d = frame_byte(job_i, '0);
          last_d = 1'b0;
        end else begin
          data_d = job_i.data;
          last_d = 1'b1;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    kind_q    <= kind_d;
    data_q    <= data_d;
    last_q    <= last_d;
    paired_q  <= paired_d;
    lamp_q    <= lamp_d;
    restart_q <= restart_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_kind_o       = kind_q;
  assign data_byte_o      = data_q;
  assign last_of_run_o    = last_q;
  assign paired_flag_o    = paired_q;
  assign charge_led_o     = lamp_q;
  assign restart_unpair_o = restart_q;

endmodule

`default_nettype wire

>>> src/radio_link_pairing_framer_core.sv
// Top level of the radio link pairing framer: front end, job queue, byte serialiser.
// Depends on rlpf_pkg, rlpf_front, rlpf_queue and rlpf_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event word: rx byte, send
//   tick, unpair timeout, start pairing, refuel, shoot or change address. A word
//   is taken at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel (out_valid_o / out_stall_i) carries result words; last_of_run_o
//   marks the final word of each event.
//   The first result of an event is written into the job queue on acceptance,
//   then into the output register, from which it is presented.
//   Throughput: one event per cycle unless stalled, except a send tick, which
//   occupies the serialiser for 13 frame bytes, one per cycle unless the output
//   stalls; the two-entry job queue lets the front end keep taking events meanwhile.
//   Configuration: cfg_we_i writes dead band, midpoint or controller address;
//   write only while idle.
//   Reset: link state returns to pairing, unpaired, target 0x81, counters clear,
//   queue and output empty.
//   Stall: a stalled output word holds; once the queue fills, in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none

module radio_link_pairing_framer_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [rlpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [rlpf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire [2:0]                      func_i,
  input  wire [7:0]                      rx_data_i,
  input  wire [9:0]                      joy1_sample_i,
  input  wire [9:0]                      joy2_sample_i,
  input  wire [9:0]                      pot_sample_i,
  input  wire [2:0]                      addr_index_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [1:0]                     out_kind_o,
  output logic [7:0]                     data_byte_o,
  output logic                           last_of_run_o,
  output logic                           paired_flag_o,
  output logic                           charge_led_o,
  output logic                           restart_unpair_o
);
  import rlpf_pkg::*;

  job_t new_job;
  job_t head_job;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic accept;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  rlpf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .func_i        (func_i),
    .rx_data_i     (rx_data_i),
    .joy1_sample_i (joy1_sample_i),
    .joy2_sample_i (joy2_sample_i),
    .pot_sample_i  (pot_sample_i),
    .addr_index_i  (addr_index_i),
    .job_o         (new_job)
  );

  rlpf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (new_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_job)
  );

  rlpf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (q_valid),
    .job_i            (head_job),
    .job_pop_o        (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_kind_o       (out_kind_o),
    .data_byte_o      (data_byte_o),
    .last_of_run_o    (last_of_run_o),
    .paired_flag_o    (paired_flag_o),
    .charge_led_o     (charge_led_o),
    .restart_unpair_o (restart_unpair_o)
  );

endmodule

`default_nettype wire
